// ===== rtl/rcgc_pkg.sv =====
package rcgc_pkg;

   // largest second count whose millisecond value fits in 32 bits
   localparam logic [22:0] SEC_MAX    = 23'd4294967;
   localparam logic [31:0] MS_PER_SEC = 32'd1000;

   // input commands
   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_SET_MODE   = 2'd1,
      CMD_SET_MANUAL = 2'd2,
      CMD_ONE_SHOT   = 2'd3
   } cmd_type;

   // channel modes
   typedef enum logic [1:0] {
      MODE_AUTO   = 2'd0,
      MODE_MANUAL = 2'd1,
      MODE_TIMER  = 2'd2
   } mode_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_MIN_ON     = 3'd0,
      REG_MIN_OFF    = 3'd1,
      REG_MAX_ON     = 3'd2,
      REG_MAX_REST   = 3'd3,
      REG_MAX_OFF    = 3'd4,
      REG_CYCLE_ON   = 3'd5,
      REG_CYCLE_OFF  = 3'd6,
      REG_MAN_TO     = 3'd7
   } reg_idx_type;

   // guard times held in milliseconds; zero means disabled
   typedef struct packed {
      logic [31:0] min_on_ms;
      logic [31:0] min_off_ms;
      logic [31:0] max_on_ms;
      logic [31:0] max_rest_ms;
      logic [31:0] max_off_ms;
      logic [31:0] cycle_on_ms;
      logic [31:0] cycle_off_ms;
      logic [31:0] man_to_ms;
   } cfg_type;

   localparam logic [22:0] CYCLE_ON_RESET_SEC  = 23'd3600;
   localparam logic [22:0] CYCLE_OFF_RESET_SEC = 23'd1800;

   // saturate seconds and scale to milliseconds; the saturated product fits in 32 bits
   function automatic logic [31:0] sec_to_ms(input logic [22:0] sec);
      logic [22:0] sat;
      logic [31:0] prod;
      sat  = (sec > SEC_MAX) ? SEC_MAX : sec;
      prod = {9'd0, sat} * MS_PER_SEC;
      return prod;
   endfunction

endpackage

// ===== rtl/rcgc_csr.sv =====
module rcgc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [22:0]       csr_wdata,
   output rcgc_pkg::cfg_type cfg
);
   import rcgc_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   cfg_type     cfg_rst;
   logic [31:0] wdata_ms;

   // scale once at write time so the datapath only compares
   assign wdata_ms = sec_to_ms(csr_wdata);

   // reset values: timer phases set, every other guard disabled
   assign cfg_rst = {160'd0, sec_to_ms(CYCLE_ON_RESET_SEC),
                     sec_to_ms(CYCLE_OFF_RESET_SEC), 32'd0};

   // register select
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MIN_ON:    cfg_in.min_on_ms    = wdata_ms;
            REG_MIN_OFF:   cfg_in.min_off_ms   = wdata_ms;
            REG_MAX_ON:    cfg_in.max_on_ms    = wdata_ms;
            REG_MAX_REST:  cfg_in.max_rest_ms  = wdata_ms;
            REG_MAX_OFF:   cfg_in.max_off_ms   = wdata_ms;
            REG_CYCLE_ON:  cfg_in.cycle_on_ms  = wdata_ms;
            REG_CYCLE_OFF: cfg_in.cycle_off_ms = wdata_ms;
            REG_MAN_TO:    cfg_in.man_to_ms    = wdata_ms;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_rst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/relay_channel_guard_controller_unit.sv =====
// Relay channel controller with anti-short-cycle guards. Each request
// transaction carries a command and the current millisecond time; every
// request yields exactly one response transaction with the relay state,
// the drive level, switch and refusal flags and the mode. One transaction
// is taken per clock cycle while the response side is ready; each response
// goes through the input register, then the result register, before it is offered. The
// cycle time is set by the parallel 32-bit subtract-and-compare checks of
// the guard times. Guard times are written through the csr port in seconds
// and are saturated and stored in milliseconds; write them only while no
// transaction is in flight.
module relay_channel_guard_controller_unit #(
   parameter bit ACTIVE_LOW = 1'b0
) (
   input  logic        clock,
   input  logic        reset,
   // request: command[1:0], now_ms[33:2], auto_request[34], mode_value[36:35],
   //          manual_level[37], one_shot_sec[60:38], zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // response: relay_on[0], pin_level[1], switched[2], refused[3],
   //           mode_now[5:4], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [22:0] csr_wdata
);
   import rcgc_pkg::*;

   cfg_type cfg;

   rcgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   function automatic logic reached(input logic [31:0] now, input logic [31:0] stamp,
                                    input logic [31:0] ms);
      logic [31:0] elapsed;
      elapsed = now - stamp;
      return elapsed >= ms;
   endfunction

   // input register
   logic        in_valid_ff;
   logic [1:0]  in_cmd_ff;
   logic [31:0] in_now_ff;
   logic        in_areq_ff;
   logic [1:0]  in_mode_ff;
   logic        in_level_ff;
   logic [31:0] in_shot_ms_ff;

   // channel state
   mode_type    mode_ff, mode_in;
   logic        out_on_ff, out_on_in;
   logic        manual_on_ff, manual_on_in;
   logic [31:0] last_on_ff, last_on_in;
   logic [31:0] last_off_ff, last_off_in;
   logic [31:0] cutoff_ff, cutoff_in;
   logic [31:0] phase_start_ff, phase_start_in;
   logic        on_phase_ff, on_phase_in;
   logic [31:0] man_start_ff, man_start_in;
   logic [31:0] shot_ms_ff, shot_ms_in;
   logic [31:0] shot_start_ff, shot_start_in;

   // result register
   logic        rsp_valid_ff;
   logic        switched_ff, switched_in;
   logic        refused_ff, refused_in;

   logic        rsp_free;
   logic        advance;
   logic        allow_on;
   logic        allow_off;
   logic        do_drive, drive_val;
   logic        do_ask, ask_val;
   logic        want_on;

   // handshake: the input register moves whenever the result slot frees
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // one-shot length is scaled on capture
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff     <= req_tdata[1:0];
         in_now_ff     <= req_tdata[33:2];
         in_areq_ff    <= req_tdata[34];
         in_mode_ff    <= req_tdata[36:35];
         in_level_ff   <= req_tdata[37];
         in_shot_ms_ff <= sec_to_ms(req_tdata[60:38]);
      end
   end

   // guard checks against the current stamps
   assign allow_on =
      !(last_off_ff != '0 && !reached(in_now_ff, last_off_ff, cfg.min_off_ms)) &&
      !(cfg.max_rest_ms != '0 && cutoff_ff != '0 &&
        !reached(in_now_ff, cutoff_ff, cfg.max_rest_ms));
   assign allow_off =
      !(last_on_ff != '0 && !reached(in_now_ff, last_on_ff, cfg.min_on_ms));

   // command decode and next state
   always_comb begin
      mode_in        = mode_ff;
      out_on_in      = out_on_ff;
      manual_on_in   = manual_on_ff;
      last_on_in     = last_on_ff;
      last_off_in    = last_off_ff;
      cutoff_in      = cutoff_ff;
      phase_start_in = phase_start_ff;
      on_phase_in    = on_phase_ff;
      man_start_in   = man_start_ff;
      shot_ms_in     = shot_ms_ff;
      shot_start_in  = shot_start_ff;
      switched_in    = 1'b0;
      refused_in     = 1'b0;
      do_drive       = 1'b0;
      drive_val      = 1'b0;
      do_ask         = 1'b0;
      ask_val        = 1'b0;
      want_on        = 1'b0;

      case (in_cmd_ff)
         CMD_TICK: begin
            case (mode_ff)
               MODE_AUTO: begin
                  if (out_on_ff && cfg.max_on_ms != '0 &&
                      reached(in_now_ff, last_on_ff, cfg.max_on_ms)) begin
                     cutoff_in = in_now_ff;
                     do_drive  = 1'b1;
                     drive_val = 1'b0;
                  end else begin
                     want_on = in_areq_ff ||
                        (!out_on_ff && cfg.max_off_ms != '0 && last_off_ff != '0 &&
                         reached(in_now_ff, last_off_ff, cfg.max_off_ms));
                     do_ask  = 1'b1;
                     ask_val = want_on;
                  end
               end
               MODE_MANUAL: begin
                  if (cfg.man_to_ms != '0 && man_start_ff != '0 &&
                      reached(in_now_ff, man_start_ff, cfg.man_to_ms)) begin
                     // revert to auto, relay left as it is
                     mode_in      = MODE_AUTO;
                     man_start_in = '0;
                     shot_ms_in   = '0;
                  end else begin
                     drive_val = manual_on_ff;
                     if (shot_ms_ff != '0 && manual_on_ff && shot_start_ff != '0 &&
                         reached(in_now_ff, shot_start_ff, shot_ms_ff)) begin
                        manual_on_in = 1'b0;
                        shot_ms_in   = '0;
                        drive_val    = 1'b0;
                     end
                     do_drive = 1'b1;
                  end
               end
               MODE_TIMER: begin
                  if (on_phase_ff) begin
                     if (reached(in_now_ff, phase_start_ff, cfg.cycle_on_ms)) begin
                        phase_start_in = in_now_ff;
                        on_phase_in    = 1'b0;
                        do_ask         = 1'b1;
                        ask_val        = 1'b0;
                     end
                  end else if (reached(in_now_ff, phase_start_ff, cfg.cycle_off_ms)) begin
                     phase_start_in = in_now_ff;
                     on_phase_in    = 1'b1;
                     do_ask         = 1'b1;
                     ask_val        = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_SET_MODE: begin
            // an unknown mode code is ignored
            if (in_mode_ff inside {MODE_AUTO, MODE_MANUAL, MODE_TIMER}) begin
               mode_in = mode_type'(in_mode_ff);
               if (in_mode_ff == MODE_MANUAL) begin
                  man_start_in = in_now_ff;
               end else if (in_mode_ff == MODE_TIMER) begin
                  phase_start_in = in_now_ff;
                  on_phase_in    = 1'b1;
                  do_ask         = 1'b1;
                  ask_val        = 1'b1;
               end
            end
         end
         CMD_SET_MANUAL: begin
            manual_on_in = in_level_ff;
            shot_ms_in   = '0;
            do_drive     = (mode_ff == MODE_MANUAL);
            drive_val    = in_level_ff;
         end
         default: begin
            // one-shot on
            manual_on_in  = 1'b1;
            shot_ms_in    = in_shot_ms_ff;
            shot_start_in = in_now_ff;
            do_drive      = (mode_ff == MODE_MANUAL);
            drive_val     = 1'b1;
         end
      endcase

      // guarded request: refuse or turn into a drive
      if (do_ask && ask_val != out_on_ff) begin
         if (ask_val ? allow_on : allow_off) begin
            do_drive  = 1'b1;
            drive_val = ask_val;
         end else begin
            refused_in = 1'b1;
         end
      end

      // drive the relay and stamp the edge
      if (do_drive && drive_val != out_on_ff) begin
         out_on_in   = drive_val;
         switched_in = 1'b1;
         if (drive_val) begin
            last_on_in = in_now_ff;
         end else begin
            last_off_in = in_now_ff;
         end
      end
   end

   // state update on each processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_AUTO;
         out_on_ff      <= 1'b0;
         manual_on_ff   <= 1'b0;
         last_on_ff     <= '0;
         last_off_ff    <= '0;
         cutoff_ff      <= '0;
         phase_start_ff <= '0;
         on_phase_ff    <= 1'b0;
         man_start_ff   <= '0;
         shot_ms_ff     <= '0;
         shot_start_ff  <= '0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         out_on_ff      <= out_on_in;
         manual_on_ff   <= manual_on_in;
         last_on_ff     <= last_on_in;
         last_off_ff    <= last_off_in;
         cutoff_ff      <= cutoff_in;
         phase_start_ff <= phase_start_in;
         on_phase_ff    <= on_phase_in;
         man_start_ff   <= man_start_in;
         shot_ms_ff     <= shot_ms_in;
         shot_start_ff  <= shot_start_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         switched_ff <= switched_in;
         refused_ff  <= refused_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, mode_ff, refused_ff, switched_ff,
                        out_on_ff ^ ACTIVE_LOW, out_on_ff};

endmodule
